FILE: rtl/fixed_block_pool_allocator_assert.svh
// Assertion macros for the block pool allocator.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FBPA_ASSERT(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error("fbpa: assertion failed");

// Next-cycle implication.
`define FBPA_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error("fbpa: assertion failed");

`endif

FILE: rtl/fbpa_pkg.sv
package fbpa_pkg;

  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 16;
  localparam int COUNT_W   = 9;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_TAKE    = 2'd0;
  localparam logic [OP_W-1:0] OP_RECYCLE = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;
  localparam logic [OP_W-1:0] OP_INIT    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

  localparam logic [SIZE_W-1:0]  ITEM_SIZE_RST  = 16'd1;
  localparam logic [COUNT_W-1:0] POOL_COUNT_RST = 9'd256;

  localparam int IN_DATA_W   = 40;
  localparam int IN_OP_LSB   = 0;
  localparam int IN_ADDR_LSB = 2;

  localparam int OUT_DATA_W      = 48;
  localparam int OUT_BLOCK_LSB   = 0;
  localparam int OUT_GRANT_BIT   = 32;
  localparam int OUT_IN_POOL_BIT = 33;
  localparam int OUT_COUNT_LSB   = 34;
  localparam int OUT_USED_W      = OUT_COUNT_LSB + COUNT_W;

  typedef struct packed {
    logic              written;
    logic [ADDR_W-1:0] value;
  } cell_t;

  typedef struct packed {
    logic pop;
    logic push;
    logic clear;
  } shift_ctrl_t;

endpackage

FILE: rtl/fbpa_cell.sv
module fbpa_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  fbpa_pkg::shift_ctrl_t ctrl,
  input  fbpa_pkg::cell_t     lower_i,
  input  fbpa_pkg::cell_t     upper_i,
  output fbpa_pkg::cell_t     q_o
);
  import fbpa_pkg::*;

  logic              written_r;
  logic [ADDR_W-1:0] value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= 1'b0;
    end else if (ctrl.clear) begin
      written_r <= 1'b0;
    end else if (ctrl.pop) begin
      written_r <= upper_i.written;
    end else if (ctrl.push) begin
      written_r <= lower_i.written;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      value_r <= upper_i.value;
    end else if (ctrl.push) begin
      value_r <= lower_i.value;
    end
  end

  assign q_o.written = written_r;
  assign q_o.value   = value_r;

endmodule

FILE: rtl/fbpa_chain.sv
module fbpa_chain #(
  parameter int DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fbpa_pkg::shift_ctrl_t ctrl,
  input  fbpa_pkg::cell_t       push_i,
  output fbpa_pkg::cell_t       head_o
);
  import fbpa_pkg::*;

  // cell k holds slot (stack pointer + k)
  cell_t cell_q [DEPTH];
  cell_t empty_cell;

  assign empty_cell = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    cell_t lower;
    cell_t upper;

    if (k == 0) begin : g_first
      assign lower = push_i;
    end else begin : g_mid_lo
      assign lower = cell_q[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign upper = empty_cell;
    end else begin : g_mid_hi
      assign upper = cell_q[k+1];
    end

    fbpa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .lower_i (lower),
      .upper_i (upper),
      .q_o     (cell_q[k])
    );
  end

  assign head_o = cell_q[0];

endmodule

FILE: rtl/fixed_block_pool_allocator.sv
// Block pool allocator: hands out fixed-size block addresses from a free stack
// of POOL_DEPTH slots held in a row of shift cells, one slot per cell, top of
// stack in the first cell. A take or recycle shifts the whole row in the cycle
// the word is accepted, so the next word sees the updated stack and one word
// per clock is taken while the result side keeps up; each result word passes
// the stage 1 and output registers (slot index times block size is registered
// before the base is added). Init clears the row; reset needs no clearing pass.
// The user must write config only while the block is idle; it is not enforced.
`include "fixed_block_pool_allocator_assert.svh"

module fixed_block_pool_allocator #(
  parameter int POOL_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]        cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] op, [33:2] address, [39:34] zero
  input  logic [fbpa_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] block_address, [32] granted, [33] in_pool, [42:34] taken_count,
  // [47:43] zero
  output logic [fbpa_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import fbpa_pkg::*;

  localparam int SP_W   = $clog2(POOL_DEPTH + 1);
  localparam int CNT_W  = (SP_W > COUNT_W) ? SP_W : COUNT_W;
  localparam int PROD_W = CNT_W + SIZE_W;
  localparam int CMP_W  = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

  // configuration
  logic [ADDR_W-1:0]  base_r;
  logic [SIZE_W-1:0]  size_r;
  logic [COUNT_W-1:0] count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      size_r  <= ITEM_SIZE_RST;
      count_r <= POOL_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE:  base_r  <= cfg_data;
        REG_SIZE:  size_r  <= cfg_data[SIZE_W-1:0];
        REG_COUNT: count_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // accept side
  logic [OP_W-1:0]   in_op;
  logic [ADDR_W-1:0] in_addr;
  logic              in_fire;
  logic              out_free;

  assign in_op   = in_tdata[IN_OP_LSB +: OP_W];
  assign in_addr = in_tdata[IN_ADDR_LSB +: ADDR_W];

  logic [SP_W-1:0]  sp_r;
  logic [SP_W-1:0]  sp_nxt;
  logic [CNT_W-1:0] sp_ext;
  logic [CNT_W-1:0] sp_nxt_ext;
  logic [CNT_W-1:0] count_ext;
  logic [CNT_W-1:0] count_eff;
  logic [CNT_W-1:0] mul_a;
  logic             can_take;
  logic             can_put;
  shift_ctrl_t      ctrl;
  cell_t            head;
  cell_t            push_cell;

  assign count_ext = CNT_W'(count_r);
  assign count_eff = (count_ext > CNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : count_ext;
  assign sp_ext    = CNT_W'(sp_r);
  assign can_take  = sp_ext < count_eff;
  assign can_put   = sp_r != '0;

  assign ctrl.pop   = in_fire && (in_op == OP_TAKE) && can_take;
  assign ctrl.push  = in_fire && (in_op == OP_RECYCLE) && can_put;
  assign ctrl.clear = in_fire && (in_op == OP_INIT);

  assign push_cell.written = 1'b1;
  assign push_cell.value   = in_addr;

  always_comb begin
    sp_nxt = sp_r;
    if (ctrl.clear) begin
      sp_nxt = '0;
    end else if (ctrl.pop) begin
      sp_nxt = sp_r + 1'b1;
    end else if (ctrl.push) begin
      sp_nxt = sp_r - 1'b1;
    end
  end

  assign sp_nxt_ext = CNT_W'(sp_nxt);
  assign mul_a      = (in_op == OP_CHECK) ? count_eff : sp_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  fbpa_chain #(
    .DEPTH (POOL_DEPTH)
  ) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .push_i (push_cell),
    .head_o (head)
  );

  // stage 1: operands and product
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic [OP_W-1:0]    s1_op_r;
  logic [ADDR_W-1:0]  s1_addr_r;
  logic               s1_grant_r;
  cell_t              s1_head_r;
  logic [PROD_W-1:0]  s1_prod_r;
  logic [COUNT_W-1:0] s1_cnt_r;

  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_op;
      s1_addr_r  <= in_addr;
      s1_grant_r <= ctrl.pop || ctrl.push;
      s1_head_r  <= head;
      s1_prod_r  <= PROD_W'(mul_a * size_r);
      s1_cnt_r   <= sp_nxt_ext[COUNT_W-1:0];
    end
  end

  // stage 2: result word
  logic [ADDR_W-1:0] blk;
  logic              inp;

  always_comb begin
    blk = '0;
    inp = 1'b0;
    case (s1_op_r) inside
      OP_TAKE: begin
        if (s1_grant_r) begin
          blk = s1_head_r.written ? s1_head_r.value : base_r + ADDR_W'(s1_prod_r);
        end
      end
      OP_CHECK: begin
        if (s1_addr_r >= base_r && CMP_W'(s1_addr_r - base_r) < CMP_W'(s1_prod_r)) begin
          inp = 1'b1;
        end
      end
      OP_RECYCLE, OP_INIT: ;
      default: ;
    endcase
  end

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_data_nxt                           = '0;
    out_data_nxt[OUT_BLOCK_LSB +: ADDR_W]  = blk;
    out_data_nxt[OUT_GRANT_BIT]            = s1_grant_r;
    out_data_nxt[OUT_IN_POOL_BIT]          = inp;
    out_data_nxt[OUT_COUNT_LSB +: COUNT_W] = s1_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `FBPA_ASSERT(a_sp_range, clk, rst_n, 1'b1, sp_ext <= CNT_W'(POOL_DEPTH))
  `FBPA_ASSERT(a_ctrl_excl, clk, rst_n, 1'b1, $onehot0({ctrl.pop, ctrl.push, ctrl.clear}))
  `FBPA_ASSERT_NEXT(a_take_step, clk, rst_n, ctrl.pop, sp_r == $past(sp_r) + 1'b1)
  `FBPA_ASSERT_NEXT(a_init_clear, clk, rst_n, ctrl.clear, sp_r == '0 && !head.written)
  `FBPA_ASSERT(a_out_excl, clk, rst_n, out_tvalid, !(out_tdata[OUT_GRANT_BIT] && out_tdata[OUT_IN_POOL_BIT]))

endmodule
